@@ rtl/ngtp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngtp_pkg
// Types and constants shared by the n-gram token position generator.
// ----------------------------------------------------------------------------
package ngtp_pkg;

  localparam logic [3:0] GRAM_LIMIT   = 4'd8;
  localparam logic [3:0] DEFAULT_GRAM = 4'd2;

  // register indexes of the write port
  localparam logic CFG_MIN_GRAM = 1'b0;
  localparam logic CFG_MAX_GRAM = 1'b1;

  typedef struct packed {
    logic [3:0] text_length;
    logic       search_mode;
  } item_t;

  typedef struct packed {
    logic [2:0] token_offset;
    logic [3:0] token_length;
    logic       is_short;
    logic [3:0] short_min_length;
    logic       last;
  } token_t;

  typedef struct packed {
    logic [3:0] min_len;
    logic [3:0] max_len;
  } gram_cfg_t;

  typedef struct packed {
    logic [3:0] len;
    logic       srch;
    logic [3:0] tail;
    logic [3:0] head;
    logic [3:0] cur;
    logic [3:0] limit;
    logic       shrt;
  } walk_t;

  typedef struct packed {
    logic   emit;
    logic   done;
    token_t tok;
    walk_t  next;
  } step_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } fsm_t;

endpackage
`default_nettype wire

@@ rtl/ngtp_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngtp_cfg
// Gram length registers with clamping to the usable range.
// ----------------------------------------------------------------------------
module ngtp_cfg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic               wr_index,
  input  wire logic [3:0]         wr_data,
  output ngtp_pkg::gram_cfg_t     cfg
);
  import ngtp_pkg::*;

  logic [3:0] min_gram_len;
  logic [3:0] max_gram_len;
  logic [3:0] min_eff;
  logic [3:0] max_clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gram_len <= DEFAULT_GRAM;
      max_gram_len <= DEFAULT_GRAM;
    end else if (wr_en) begin
      case (wr_index)
        CFG_MIN_GRAM: min_gram_len <= wr_data;
        CFG_MAX_GRAM: max_gram_len <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (min_gram_len == 4'd0) begin
      min_eff = 4'd1;
    end else if (min_gram_len > GRAM_LIMIT) begin
      min_eff = GRAM_LIMIT;
    end else begin
      min_eff = min_gram_len;
    end
    max_clip    = (max_gram_len > GRAM_LIMIT) ? GRAM_LIMIT : max_gram_len;
    cfg.min_len = min_eff;
    cfg.max_len = (max_clip < min_eff) ? min_eff : max_clip;
  end

endmodule
`default_nettype wire

@@ rtl/ngtp_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngtp_step
// Step unit: from the walk state it forms at most one token and the
// following walk state, and it builds the starting state of a new text.
// ----------------------------------------------------------------------------
module ngtp_step (
  input  wire ngtp_pkg::gram_cfg_t cfg,
  input  wire ngtp_pkg::walk_t     st,
  input  wire logic [3:0]          start_len,
  input  wire logic                start_srch,
  output ngtp_pkg::walk_t          init,
  output ngtp_pkg::step_t          res
);
  import ngtp_pkg::*;

  // search mode stops once the remaining text is shorter than the maximum
  function automatic logic stops(input walk_t w, input logic [3:0] mx);
    stops = w.srch && (w.cur < mx) && (w.tail != 4'd0) && (w.head == w.len) &&
            !(w.cur < w.limit);
  endfunction

  logic [3:0] init_cur;
  logic [3:0] tail_inc;
  logic [3:0] cur_sel;
  logic [4:0] head_sum;
  logic [4:0] lim_sum;
  logic [3:0] limit_n;
  walk_t      nx;

  always_comb begin
    init_cur  = start_srch ? cfg.max_len : cfg.min_len;
    init.len  = start_len;
    init.srch = start_srch;
    init.tail = 4'd0;
    init.shrt = 1'b0;
    if (init_cur > start_len) begin
      init.head  = start_len;
      init.limit = start_len;
      init.cur   = start_len;
      init.shrt  = start_srch && (cfg.min_len > start_len);
    end else begin
      init.head  = init_cur;
      init.limit = (cfg.max_len > start_len) ? start_len : cfg.max_len;
      init.cur   = init_cur;
    end
  end

  always_comb begin
    tail_inc = st.tail + 4'd1;
    cur_sel  = st.srch ? cfg.max_len : cfg.min_len;
    head_sum = {1'b0, tail_inc} + {1'b0, cur_sel};
    lim_sum  = {1'b0, tail_inc} + {1'b0, cfg.max_len};
    limit_n  = st.len - tail_inc;

    nx                         = st;
    res.emit                   = 1'b1;
    res.done                   = 1'b0;
    res.tok.token_offset       = st.tail[2:0];
    res.tok.token_length       = st.cur;
    res.tok.is_short           = 1'b0;
    res.tok.short_min_length   = 4'd0;
    res.tok.last               = 1'b0;

    if (st.shrt) begin
      res.tok.is_short         = 1'b1;
      res.tok.short_min_length = cfg.min_len;
      res.done                 = 1'b1;
    end else if (st.cur < st.limit) begin
      nx.cur  = st.cur + 4'd1;
      nx.head = st.head + 4'd1;
    end else if (stops(st, cfg.max_len)) begin
      res.emit = 1'b0;
      res.done = 1'b1;
    end else begin
      nx.tail = tail_inc;
      if (tail_inc >= st.len) begin
        res.done = 1'b1;
      end
      nx.head = (head_sum >= {1'b0, st.len}) ? st.len : head_sum[3:0];
      if (lim_sum >= {1'b0, st.len}) begin
        nx.limit = limit_n;
        nx.cur   = (cur_sel > limit_n) ? limit_n : cur_sel;
      end else begin
        nx.limit = cfg.max_len;
        nx.cur   = cur_sel;
      end
    end

    // the walk also ends when the following state would stop at once
    if (!res.done && stops(nx, cfg.max_len)) begin
      res.done = 1'b1;
    end
    res.tok.last = res.emit && res.done;
    res.next     = nx;
  end

endmodule
`default_nettype wire

@@ rtl/ngram_token_position_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngram_token_position_generator
// Emits the n-gram tokens of a text as offset and length pairs.
// ----------------------------------------------------------------------------
//  channel  signals                       direction  moves
//  item     item_valid/item_ready/item    in         one text request
//  token    token_valid/token_ready/token out        one token
//  config   wr_en/wr_index/wr_data        in         gram length write
//
//  a request is taken while idle, then the step unit gives one token per
//  cycle while the output register is free, at most 36 tokens for an
//  eight character text; an empty text gives none
//  item_ready is high only while no text is being walked
//  a stalled token register holds the step unit until taken
//  synchronous reset sets both gram lengths to 2 and returns to idle
// ----------------------------------------------------------------------------
module ngram_token_position_generator #(
  parameter int MAX_TEXT_LEN = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire ngtp_pkg::item_t  item,
  output logic                  token_valid,
  input  wire logic             token_ready,
  output ngtp_pkg::token_t      token,
  input  wire logic             wr_en,
  input  wire logic             wr_index,
  input  wire logic [3:0]       wr_data
);
  import ngtp_pkg::*;

  localparam logic [3:0] TEXT_CAP = 4'(MAX_TEXT_LEN);

  gram_cfg_t  cfg;
  walk_t      st;
  walk_t      init;
  step_t      res;
  fsm_t       fsm;
  fsm_t       fsm_next;
  logic [3:0] len_eff;
  logic       accept;
  logic       adv;

  ngtp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  ngtp_step u_step (
    .cfg        (cfg),
    .st         (st),
    .start_len  (len_eff),
    .start_srch (item.search_mode),
    .init       (init),
    .res        (res)
  );

  assign len_eff = (item.text_length > TEXT_CAP) ? TEXT_CAP : item.text_length;
  assign accept  = item_valid && item_ready;

  always_comb begin
    item_ready = (fsm == ST_IDLE);
    adv        = (fsm == ST_RUN) && (!token_valid || token_ready);
  end

  always_comb begin
    fsm_next = fsm;
    case (fsm)
      ST_IDLE: begin
        if (accept && (len_eff != 4'd0)) begin
          fsm_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv && res.done) begin
          fsm_next = ST_IDLE;
        end
      end
      default: fsm_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm         <= ST_IDLE;
      token_valid <= 1'b0;
    end else begin
      fsm <= fsm_next;
      if (adv && res.emit) begin
        token_valid <= 1'b1;
      end else if (token_ready) begin
        token_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st <= init;
    end else if (adv) begin
      st <= res.next;
    end
    if (adv && res.emit) begin
      token <= res.tok;
    end
  end

  // a short word is always the only and final token
  a_short_last: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.is_short |-> token.last)
    else $error("short word token without last");

  a_short_len: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token.is_short |-> token.short_min_length == 4'd0)
    else $error("short minimum on a normal token");

  a_tok_len: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> token.token_length != 4'd0)
    else $error("zero length token");

  a_run_cur: assert property (@(posedge clk) disable iff (rst)
    fsm == ST_RUN |-> st.cur != 4'd0)
    else $error("walk running with zero gram length");

endmodule
`default_nettype wire
